// ===== hw/rtl/gf2ed_pkg.sv =====
package gf2ed_pkg;

    localparam int SYMBOLS     = 6;
    localparam int SYMBOL_BITS = 8;
    localparam int SYM_IDX_W   = $clog2(SYMBOLS);
    localparam int CFG_IDX_W   = $clog2(SYMBOLS);

    typedef logic [SYMBOLS-1:0]     row_t;
    typedef logic [SYMBOL_BITS-1:0] sym_t;
    typedef logic [SYM_IDX_W-1:0]   sym_idx_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

    typedef struct packed {
        sym_t survivor_5;
        sym_t survivor_4;
        sym_t survivor_3;
        sym_t survivor_2;
        sym_t survivor_1;
        sym_t survivor_0;
    } in_item_t;

    typedef struct packed {
        sym_t data_5;
        sym_t data_4;
        sym_t data_3;
        sym_t data_2;
        sym_t data_1;
        sym_t data_0;
    } out_item_t;

    // status of the matrix inverter
    typedef struct packed {
        logic busy;
    } inv_status_t;

endpackage

// ===== hw/rtl/gf2ed_inv.sv =====
module gf2ed_inv (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  gf2ed_pkg::row_t      coef [gf2ed_pkg::SYMBOLS],
    output gf2ed_pkg::row_t      inv  [gf2ed_pkg::SYMBOLS],
    output gf2ed_pkg::inv_status_t status
);
    import gf2ed_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t   state_reg, state_next;
    row_t     m_reg   [SYMBOLS];
    row_t     m_next  [SYMBOLS];
    row_t     inv_reg [SYMBOLS];
    row_t     inv_next[SYMBOLS];
    sym_idx_t col_reg, col_next;

    // one elimination column per cycle
    always_comb begin
        row_t     m_w   [SYMBOLS];
        row_t     inv_w [SYMBOLS];
        row_t     tmp_m;
        row_t     tmp_i;
        logic     found;
        sym_idx_t piv;

        m_w        = m_reg;
        inv_w      = inv_reg;
        found      = 1'b0;
        piv        = '0;
        tmp_m      = '0;
        tmp_i      = '0;
        state_next = state_reg;
        col_next   = col_reg;
        m_next     = m_reg;
        inv_next   = inv_reg;

        // first row at or below the diagonal with the column bit set
        for (int r = 0; r < SYMBOLS; r++) begin
            if (!found && (sym_idx_t'(r) >= col_reg) && m_reg[r][col_reg]) begin
                found = 1'b1;
                piv   = sym_idx_t'(r);
            end
        end

        if (found) begin
            for (int r = 0; r < SYMBOLS; r++) begin
                if ((sym_idx_t'(r) != piv) && m_reg[r][col_reg]) begin
                    m_w[r]   = m_reg[r] ^ m_reg[piv];
                    inv_w[r] = inv_reg[r] ^ inv_reg[piv];
                end
            end
            tmp_m          = m_w[col_reg];
            tmp_i          = inv_w[col_reg];
            m_w[col_reg]   = m_w[piv];
            inv_w[col_reg] = inv_w[piv];
            m_w[piv]       = tmp_m;
            inv_w[piv]     = tmp_i;
        end

        // a new row write restarts the pass from column 0, even mid-run
        if (start) begin
            for (int r = 0; r < SYMBOLS; r++) begin
                m_next[r]   = coef[r];
                inv_next[r] = row_t'(1) << r;
            end
            col_next   = '0;
            state_next = ST_RUN;
        end else begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_RUN: begin
                    m_next   = m_w;
                    inv_next = inv_w;
                    if (col_reg == sym_idx_t'(SYMBOLS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            for (int r = 0; r < SYMBOLS; r++) begin
                m_reg[r]   <= row_t'(1) << r;
                inv_reg[r] <= row_t'(1) << r;
            end
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            m_reg     <= m_next;
            inv_reg   <= inv_next;
        end
    end

    assign inv         = inv_reg;
    assign status.busy = (state_reg == ST_RUN);

endmodule

// ===== hw/rtl/gf2ed_lane.sv =====
module gf2ed_lane (
    input  logic            aclk,
    input  logic            load,
    input  gf2ed_pkg::row_t sel,
    input  gf2ed_pkg::sym_t syms [gf2ed_pkg::SYMBOLS],
    output gf2ed_pkg::sym_t data
);
    import gf2ed_pkg::*;

    sym_t data_reg, data_next;

    // xor of the survivors picked by this inverse row
    always_comb begin
        data_next = '0;
        for (int j = 0; j < SYMBOLS; j++) begin
            if (sel[j]) begin
                data_next = data_next ^ syms[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/gf2_erasure_decoder.sv =====
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+-----------------------------------
// s_       | in  | s_valid / s_ready | s_data: survivor_0 .. survivor_5
// m_       | out | m_valid / m_ready | m_data: data_0 .. data_5
// cfg_     | in  | cfg_wr_en         | cfg_index, cfg_wr_data (coef rows)
//
// one item per cycle while s_ready is high; each item shows up on m_ in the cycle after it is taken
// a row write starts a gauss-jordan pass, one column per cycle; s_ready is
// low while a row write is pending and while the inverter runs
// reset loads the identity submatrix, whose inverse is ready at once
// the output register is refilled in the cycle it is taken, so a stall on
// m_ready only holds s_ready low while the register stays full
module gf2_erasure_decoder (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  gf2ed_pkg::in_item_t      s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output gf2ed_pkg::out_item_t     m_data,
    input  logic                     cfg_wr_en,
    input  gf2ed_pkg::cfg_idx_t      cfg_index,
    input  gf2ed_pkg::row_t          cfg_wr_data
);
    import gf2ed_pkg::*;

    // coefficient rows, identity after reset
    row_t        coef_reg [SYMBOLS];
    row_t        coef_next[SYMBOLS];
    logic        start_reg, start_next;
    row_t        inv_rows [SYMBOLS];
    inv_status_t inv_status;

    logic        m_valid_reg, m_valid_next;
    logic        accept;
    sym_t        syms     [SYMBOLS];
    sym_t        lane_data[SYMBOLS];

    // register writes; an index past the last row is dropped
    always_comb begin
        coef_next  = coef_reg;
        start_next = 1'b0;
        if (cfg_wr_en && (cfg_index < cfg_idx_t'(SYMBOLS))) begin
            coef_next[cfg_index] = cfg_wr_data;
            start_next           = 1'b1;
        end
    end

    // inverter restarts on every row write
    gf2ed_inv u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .coef    (coef_reg),
        .inv     (inv_rows),
        .status  (inv_status)
    );

    // input item unpacked for the lanes
    assign syms[0] = s_data.survivor_0;
    assign syms[1] = s_data.survivor_1;
    assign syms[2] = s_data.survivor_2;
    assign syms[3] = s_data.survivor_3;
    assign syms[4] = s_data.survivor_4;
    assign syms[5] = s_data.survivor_5;

    // take an item when the inverse is settled and the output slot frees up
    assign s_ready = !inv_status.busy && !start_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // one lane per recovered symbol, each holds its output register
    for (genvar i = 0; i < SYMBOLS; i++) begin : g_lane
        gf2ed_lane u_lane (
            .aclk (aclk),
            .load (accept),
            .sel  (inv_rows[i]),
            .syms (syms),
            .data (lane_data[i])
        );
    end

    // output valid follows accepts and drains on m_ready
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int r = 0; r < SYMBOLS; r++) begin
                coef_reg[r] <= row_t'(1) << r;
            end
        end else begin
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            coef_reg    <= coef_next;
        end
    end

    // merge lane results into the result item
    assign m_valid       = m_valid_reg;
    assign m_data.data_0 = lane_data[0];
    assign m_data.data_1 = lane_data[1];
    assign m_data.data_2 = lane_data[2];
    assign m_data.data_3 = lane_data[3];
    assign m_data.data_4 = lane_data[4];
    assign m_data.data_5 = lane_data[5];

endmodule
